// ----- src/imhq_pkg.sv -----
package imhq_pkg;

   // Fixed field widths
   localparam int ACTION_W = 2;
   localparam int HANDLE_W = 14;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   // Default sizing
   localparam int HEAP_DEPTH_DEF   = 1024;
   localparam int HANDLE_COUNT_DEF = 16384;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DECREASE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd3;

   // Response status
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

   // One heap slot
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
   } entry_type;

endpackage

// ----- src/imhq_req_if.sv -----
interface imhq_req_if import imhq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [HANDLE_W-1:0] handle;
   logic [KEY_W-1:0]    key;

   modport source (output valid, output action, output handle, output key, input ready);
   modport sink   (input valid, input action, input handle, input key, output ready);
endinterface

// ----- src/imhq_rsp_if.sv -----
interface imhq_rsp_if import imhq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] out_handle;
   logic [KEY_W-1:0]    out_key;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output out_handle, output out_key, output status,
                   output count, input ready);
   modport sink   (input valid, input out_handle, input out_key, input status,
                   input count, output ready);
endinterface

// ----- src/indexed_min_heap_queue_top.sv -----
// Channel  | Dir | Handshake           | Payload
// req_chan | in  | valid/ready         | action, handle, key
// rsp_chan | out | valid/ready         | out_handle, out_key, status, count
//
// One request at a time; req_chan.ready is high only while the sequencer is idle.
// Each level moved costs one slot read and compare in sift-up, two reads and a compare in sift-down.
// Reset (synchronous) empties the queue; memory contents are not cleared.
// A held response stalls only the finish of the next request, not its acceptance.
module indexed_min_heap_queue_top import imhq_pkg::*; #(
   parameter int HEAP_DEPTH   = HEAP_DEPTH_DEF,
   parameter int HANDLE_COUNT = HANDLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   imhq_req_if.sink    req_chan,
   imhq_rsp_if.source  rsp_chan
);

   localparam int SW     = $clog2(HEAP_DEPTH);
   localparam int CW     = $clog2(HEAP_DEPTH + 1);
   localparam int XW     = SW + 2;
   localparam int MAP_AW = $clog2(HANDLE_COUNT);
   localparam int EW     = $bits(entry_type);

   // Sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RM_ROOT = 4'd1;
   localparam logic [3:0] S_RM_LAST = 4'd2;
   localparam logic [3:0] S_UP_RD   = 4'd3;
   localparam logic [3:0] S_UP_CMP  = 4'd4;
   localparam logic [3:0] S_DN_RL   = 4'd5;
   localparam logic [3:0] S_DN_RR   = 4'd6;
   localparam logic [3:0] S_DN_CMP  = 4'd7;
   localparam logic [3:0] S_DK_MAP  = 4'd8;
   localparam logic [3:0] S_DK_SLOT = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [SW-1:0]       idx_ff, idx_in;
   entry_type           cur_ff, cur_in;
   entry_type           best_ff, best_in;
   logic                best_left_ff, best_left_in;
   logic                right_ok_ff, right_ok_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Memory ports
   logic              slot_wr_en;
   logic [SW-1:0]     slot_wr_addr;
   entry_type         slot_wr_data;
   logic [SW-1:0]     slot_rd_addr;
   logic [EW-1:0]     slot_rd_raw;
   entry_type         slot_rd;
   logic              map_wr_en;
   logic [MAP_AW-1:0] map_wr_addr;
   logic [SW-1:0]     map_wr_data;
   logic [MAP_AW-1:0] map_rd_addr;
   logic [SW-1:0]     map_rd_data;

   logic              accept;
   logic              in_range;
   logic [XW-1:0]     left_x, right_x, count_x;
   logic [SW-1:0]     parent;
   logic              out_free;

   assign slot_rd = entry_type'(slot_rd_raw);

   imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_raw)
   );

   imhq_ram #(.WIDTH(SW), .DEPTH(HANDLE_COUNT)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Handshake and index arithmetic
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && (state_ff == S_IDLE);
   assign in_range       = (32'(req_chan.handle) < 32'(HANDLE_COUNT));
   assign left_x         = XW'({idx_ff, 1'b1});
   assign right_x        = left_x + XW'(1);
   assign count_x        = XW'(count_ff);
   assign parent         = SW'((idx_ff - SW'(1)) >> 1);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_left_in  = best_left_ff;
      right_ok_in   = right_ok_ff;
      res_handle_in = res_handle_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;

      slot_wr_en   = 1'b0;
      slot_wr_addr = idx_ff;
      slot_wr_data = cur_ff;
      slot_rd_addr = '0;
      map_wr_en    = 1'b0;
      map_wr_addr  = MAP_AW'(cur_ff.handle);
      map_wr_data  = idx_ff;
      map_rd_addr  = MAP_AW'(req_chan.handle);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_handle_in = '0;
               res_key_in    = '0;
               res_status_in = ST_OK;
               cur_in.handle = req_chan.handle;
               cur_in.key    = req_chan.key;
               unique case (req_chan.action)
                  ACT_INSERT: begin
                     if (count_ff >= CW'(HEAP_DEPTH)) begin
                        res_status_in = ST_FULL;
                        state_in      = S_DONE;
                     end else if (!in_range) begin
                        res_status_in = ST_ABSENT;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = SW'(count_ff);
                        count_in = count_ff + CW'(1);
                        state_in = S_UP_RD;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        slot_rd_addr = '0;
                        state_in     = S_RM_ROOT;
                     end
                  end
                  ACT_DECREASE: begin
                     if (!in_range) begin
                        res_status_in = ST_ABSENT;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_DK_MAP;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // Root is out; fetch the last entry
         S_RM_ROOT: begin
            res_handle_in = slot_rd.handle;
            res_key_in    = slot_rd.key;
            slot_rd_addr  = SW'(count_ff - CW'(1));
            count_in      = count_ff - CW'(1);
            state_in      = S_RM_LAST;
         end

         S_RM_LAST: begin
            cur_in = slot_rd;
            idx_in = '0;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DN_RL;
            end
         end

         // Sift up: moving entry stays in cur_ff, parents shift down
         S_UP_RD: begin
            if (idx_ff == '0) begin
               slot_wr_en = 1'b1;
               map_wr_en  = 1'b1;
               state_in   = S_DONE;
            end else begin
               slot_rd_addr = parent;
               state_in     = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            slot_wr_en = 1'b1;
            map_wr_en  = 1'b1;
            if (cur_ff.key < slot_rd.key) begin
               slot_wr_data = slot_rd;
               map_wr_addr  = MAP_AW'(slot_rd.handle);
               idx_in       = parent;
               state_in     = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end

         // Sift down: read left child
         S_DN_RL: begin
            if (left_x >= count_x) begin
               slot_wr_en = 1'b1;
               map_wr_en  = 1'b1;
               state_in   = S_DONE;
            end else begin
               slot_rd_addr = SW'(left_x);
               state_in     = S_DN_RR;
            end
         end

         // Left child in hand; read right child and note whether it is present
         S_DN_RR: begin
            if (slot_rd.key < cur_ff.key) begin
               best_in      = slot_rd;
               best_left_in = 1'b1;
            end else begin
               best_in      = cur_ff;
               best_left_in = 1'b0;
            end
            right_ok_in  = (right_x < count_x);
            slot_rd_addr = SW'(right_x);
            state_in     = S_DN_CMP;
         end

         S_DN_CMP: begin
            slot_wr_en = 1'b1;
            map_wr_en  = 1'b1;
            if (right_ok_ff && (slot_rd.key < best_ff.key)) begin
               slot_wr_data = slot_rd;
               map_wr_addr  = MAP_AW'(slot_rd.handle);
               idx_in       = SW'(right_x);
               state_in     = S_DN_RL;
            end else if (best_left_ff) begin
               slot_wr_data = best_ff;
               map_wr_addr  = MAP_AW'(best_ff.handle);
               idx_in       = SW'(left_x);
               state_in     = S_DN_RL;
            end else begin
               state_in = S_DONE;
            end
         end

         // Decrease key: check that the map entry is live
         S_DK_MAP: begin
            if (CW'(map_rd_data) < count_ff) begin
               slot_rd_addr = map_rd_data;
               idx_in       = map_rd_data;
               state_in     = S_DK_SLOT;
            end else begin
               res_status_in = ST_ABSENT;
               state_in      = S_DONE;
            end
         end

         S_DK_SLOT: begin
            if (slot_rd.handle == cur_ff.handle) begin
               state_in = S_UP_RD;
            end else begin
               res_status_in = ST_ABSENT;
               state_in      = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = res_handle_ff;
         rsp_key_in    = res_key_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_left_ff  <= best_left_in;
      right_ok_ff   <= right_ok_in;
      res_handle_ff <= res_handle_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_handle = rsp_handle_ff;
   assign rsp_chan.out_key    = rsp_key_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.count      = rsp_count_ff;

endmodule

// ----- src/imhq_ram.sv -----
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/imhq_checker.sv -----
module imhq_checker import imhq_pkg::*; #(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [HANDLE_W-1:0] rsp_out_handle,
   input logic [KEY_W-1:0]    rsp_out_key,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [COUNT_W-1:0]  rsp_count
);

   // A waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_handle)
         && $stable(rsp_out_key) && $stable(rsp_status) && $stable(rsp_count))
      else $error("response changed while stalled");

   // One request in flight: ready drops after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Full is reported only with a full queue
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_count == COUNT_W'(HEAP_DEPTH))
      else $error("full status with room left");

   // Failed requests return no entry
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_out_handle == '0) && (rsp_out_key == '0))
      else $error("entry returned on failed request");

   // No response right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_min_heap_queue_top imhq_checker #(.HEAP_DEPTH(HEAP_DEPTH)) u_imhq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_handle (rsp_chan.out_handle),
   .rsp_out_key    (rsp_chan.out_key),
   .rsp_status     (rsp_chan.status),
   .rsp_count      (rsp_chan.count)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import imhq_pkg::*;

   localparam int HEAP_DEPTH   = HEAP_DEPTH_DEF;
   localparam int HANDLE_COUNT = HANDLE_COUNT_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int PAUSE_AT     = 400;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 64;

   // One response as the queue should report it
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } heap_outcome_type;

   // One row of the directed table
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      bit                  typed;
      heap_outcome_type    want;
   } stim_row_type;

   localparam heap_outcome_type NO_TYPED = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   imhq_req_if req_bus ();
   imhq_rsp_if rsp_bus ();

   indexed_min_heap_queue_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the heap
   bit [HANDLE_W-1:0] shadow_handle [HEAP_DEPTH];
   bit [KEY_W-1:0]    shadow_key    [HEAP_DEPTH];
   int unsigned       shadow_slot   [HANDLE_COUNT];
   int unsigned       shadow_size;

   // Handles whose map entry has been written at least once
   bit                  ever_mapped [HANDLE_COUNT];
   logic [HANDLE_W-1:0] mapped_handles [$];

   heap_outcome_type expected_outcomes [$];
   stim_row_type     directed_rows [$];

   bit          steady;
   int unsigned mismatches;
   int unsigned checked_total;
   int unsigned sent_total;
   int unsigned peak_size;
   int unsigned status_tally [4];

   always #6 clock = ~clock;

   function automatic void shadow_put(int unsigned slot, bit [HANDLE_W-1:0] h,
                                      bit [KEY_W-1:0] k);
      shadow_handle[slot] = h;
      shadow_key[slot]    = k;
      shadow_slot[h]      = slot;
   endfunction

   function automatic void shadow_swap(int unsigned a, int unsigned b);
      bit [HANDLE_W-1:0] ha;
      bit [KEY_W-1:0]    ka;
      ha = shadow_handle[a];
      ka = shadow_key[a];
      shadow_put(a, shadow_handle[b], shadow_key[b]);
      shadow_put(b, ha, ka);
   endfunction

   // Climb while strictly smaller than the parent
   function automatic void shadow_rise(int unsigned start);
      int unsigned i, up;
      i = start;
      while (i > 0) begin
         up = (i - 1) / 2;
         if (shadow_key[i] >= shadow_key[up]) break;
         shadow_swap(i, up);
         i = up;
      end
   endfunction

   // Apply one request to the shadow heap and return its response
   function automatic heap_outcome_type predict_outcome(logic [ACTION_W-1:0] action,
                                                        logic [HANDLE_W-1:0] h,
                                                        logic [KEY_W-1:0] k);
      heap_outcome_type res;
      int unsigned      pos, i, best, left, right;
      res = '0;
      case (action)
         ACT_INSERT: begin
            if (shadow_size >= HEAP_DEPTH) begin
               res.status = ST_FULL;
            end else if (int'(h) >= HANDLE_COUNT) begin
               res.status = ST_ABSENT;
            end else begin
               shadow_put(shadow_size, h, k);
               shadow_size++;
               shadow_rise(shadow_size - 1);
            end
         end
         ACT_REMOVE: begin
            if (shadow_size == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.handle = shadow_handle[0];
               res.key    = shadow_key[0];
               shadow_size--;
               if (shadow_size > 0) begin
                  shadow_put(0, shadow_handle[shadow_size], shadow_key[shadow_size]);
                  // sift down; right child wins only if strictly below the left
                  best = 0;
                  do begin
                     i     = best;
                     left  = 2 * i + 1;
                     right = 2 * i + 2;
                     if (left < shadow_size && shadow_key[left] < shadow_key[best])
                        best = left;
                     if (right < shadow_size && shadow_key[right] < shadow_key[best])
                        best = right;
                     if (best != i) shadow_swap(i, best);
                  end while (best != i);
               end
            end
         end
         ACT_DECREASE: begin
            pos = (int'(h) < HANDLE_COUNT) ? shadow_slot[h] : 0;
            if (int'(h) >= HANDLE_COUNT || pos >= shadow_size || shadow_handle[pos] != h) begin
               res.status = ST_ABSENT;
            end else begin
               // a larger key is still written, it just never moves down
               shadow_key[pos] = k;
               shadow_rise(pos);
            end
         end
         default: begin
            shadow_size = 0;
         end
      endcase
      res.count = COUNT_W'(shadow_size);
      return res;
   endfunction

   function automatic heap_outcome_type outcome(logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] k,
                                                logic [STATUS_W-1:0] st,
                                                logic [COUNT_W-1:0] cnt);
      heap_outcome_type res;
      res.handle = h;
      res.key    = k;
      res.status = st;
      res.count  = cnt;
      return res;
   endfunction

   function automatic void add_row(logic [ACTION_W-1:0] action, logic [HANDLE_W-1:0] h,
                                   logic [KEY_W-1:0] k, bit typed, heap_outcome_type want);
      stim_row_type row;
      row.action = action;
      row.handle = h;
      row.key    = k;
      row.typed  = typed;
      row.want   = want;
      directed_rows.push_back(row);
   endfunction

   // Keys: many small ones to force ties, plus the extremes
   function automatic logic [KEY_W-1:0] draw_key();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return KEY_W'($urandom_range(31));
         5, 6, 7:       return KEY_W'($urandom);
         8:             return '0;
         default:       return '1;
      endcase
   endfunction

   // Send one request, wait for acceptance, then predict its response
   task automatic issue_request(logic [ACTION_W-1:0] action, logic [HANDLE_W-1:0] h,
                                logic [KEY_W-1:0] k, bit typed,
                                heap_outcome_type typed_want);
      heap_outcome_type predicted;
      while (!steady && $urandom_range(99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= action;
      req_bus.handle <= h;
      req_bus.key    <= k;
      do @(posedge clock); while (!req_bus.ready);
      predicted = predict_outcome(action, h, k);
      if (action == ACT_INSERT && predicted.status == ST_OK && !ever_mapped[h]) begin
         ever_mapped[h] = 1'b1;
         mapped_handles.push_back(h);
      end
      status_tally[predicted.status]++;
      expected_outcomes.push_back(typed ? typed_want : predicted);
      sent_total++;
      if (shadow_size > peak_size) peak_size = shadow_size;
   endtask

   // Decrease key, mostly on a live entry and mostly to a lower key
   task automatic issue_decrease();
      int unsigned         slot;
      logic [HANDLE_W-1:0] h;
      logic [KEY_W-1:0]    k, cur;
      if (shadow_size > 0 && $urandom_range(4) != 0) begin
         slot = $urandom_range(shadow_size - 1);
         h    = shadow_handle[slot];
         cur  = shadow_key[slot];
         case ($urandom_range(5))
            0:       k = cur;
            1:       k = draw_key();
            default: k = (cur == 0) ? '0 : KEY_W'($urandom_range(cur - 1));
         endcase
      end else begin
         h = mapped_handles[$urandom_range(mapped_handles.size() - 1)];
         k = draw_key();
      end
      issue_request(ACT_DECREASE, h, k, 1'b0, NO_TYPED);
   endtask

   task automatic wait_drained();
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // Response checker and ready driver
   always @(posedge clock) begin
      heap_outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: handle %0d key %h status %0d count %0d",
                           rsp_bus.out_handle, rsp_bus.out_key, rsp_bus.status,
                           rsp_bus.count);
            end else begin
               want = expected_outcomes.pop_front();
               checked_total++;
               if (rsp_bus.out_handle !== want.handle || rsp_bus.out_key !== want.key ||
                   rsp_bus.status !== want.status || rsp_bus.count !== want.count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch on response %0d: handle %0d/%0d key %h/%h ",
                               "status %0d/%0d count %0d/%0d (expected/actual)"},
                              checked_total, want.handle, rsp_bus.out_handle, want.key,
                              rsp_bus.out_key, want.status, rsp_bus.status, want.count,
                              rsp_bus.count);
               end
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(99) >= 36);
      end
   end

   // Watchdog on cycles with no handshake on either side
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      int unsigned         n, choice;
      logic [HANDLE_W-1:0] h;
      stim_row_type        row;

      req_bus.valid  <= 1'b0;
      req_bus.action <= ACT_INSERT;
      req_bus.handle <= '0;
      req_bus.key    <= '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, extremes, ties, duplicates, larger key, clear
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b1, outcome('0, '0, ST_EMPTY, 11'd0));
      add_row(ACT_INSERT,   14'h3FFF, 32'hFFFFFFFF, 1'b1, outcome('0, '0, ST_OK, 11'd1));
      add_row(ACT_INSERT,   14'd0,    32'd0,        1'b1, outcome('0, '0, ST_OK, 11'd2));
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b1, outcome('0, '0, ST_OK, 11'd1));
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b1,
              outcome(14'h3FFF, 32'hFFFFFFFF, ST_OK, 11'd0));
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b1, outcome('0, '0, ST_EMPTY, 11'd0));
      add_row(ACT_DECREASE, 14'd0,    32'd0,        1'b1, outcome('0, '0, ST_ABSENT, 11'd0));
      add_row(ACT_INSERT,   14'd100,  32'd50,       1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd101,  32'd50,       1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd102,  32'd50,       1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd103,  32'd40,       1'b0, NO_TYPED);
      add_row(ACT_DECREASE, 14'd102,  32'd10,       1'b0, NO_TYPED);
      add_row(ACT_DECREASE, 14'd101,  32'd90,       1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd100,  32'd5,        1'b0, NO_TYPED);
      add_row(ACT_DECREASE, 14'd100,  32'd1,        1'b0, NO_TYPED);
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b0, NO_TYPED);
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b0, NO_TYPED);
      add_row(ACT_CLEAR,    14'd0,    32'd0,        1'b1, outcome('0, '0, ST_OK, 11'd0));
      add_row(ACT_DECREASE, 14'd103,  32'd0,        1'b1, outcome('0, '0, ST_ABSENT, 11'd0));
      add_row(ACT_INSERT,   14'd200,  32'd1,        1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd201,  32'd5,        1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd202,  32'd5,        1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'd203,  32'd9,        1'b0, NO_TYPED);
      add_row(ACT_REMOVE,   14'd0,    32'd0,        1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'h2AAA, 32'hAAAAAAAA, 1'b0, NO_TYPED);
      add_row(ACT_INSERT,   14'h1555, 32'h55555555, 1'b0, NO_TYPED);
      add_row(ACT_CLEAR,    14'd0,    32'd0,        1'b1, outcome('0, '0, ST_OK, 11'd0));

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue_request(row.action, row.handle, row.key, row.typed, row.want);
      end

      // Random traffic, with one full drain of responses partway through
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 300);
         if (n == PAUSE_AT) begin
            // hold off until every outstanding response is back
            req_bus.valid <= 1'b0;
            wait_drained();
         end

         choice = $urandom_range(99);
         if (choice < 42 || mapped_handles.size() == 0) begin
            // small handle pool so duplicates and repeat decreases happen
            h = ($urandom_range(9) < 2) ? HANDLE_W'($urandom) : HANDLE_W'($urandom_range(47));
            issue_request(ACT_INSERT, h, draw_key(), 1'b0, NO_TYPED);
         end else if (choice < 72) begin
            issue_request(ACT_REMOVE, HANDLE_W'($urandom), KEY_W'($urandom), 1'b0, NO_TYPED);
         end else if (choice < 97) begin
            issue_decrease();
         end else begin
            issue_request(ACT_CLEAR, HANDLE_W'($urandom), KEY_W'($urandom), 1'b0, NO_TYPED);
         end
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d responses checked, queue peaked at %0d entries",
               sent_total, checked_total, peak_size);
      $display("status mix: %0d ok, %0d empty, %0d full, %0d absent; %0d mismatches",
               status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_FULL],
               status_tally[ST_ABSENT], mismatches);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
